[sv/bsd_pkg.sv]
// shared types and constants for the binary square dilation block
`timescale 1ns / 1ps

package bsd_pkg;

	localparam int GRID_W     = 11;
	localparam int RAD_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_SIDE = 2'd0,
		REG_RADIUS    = 2'd1
	} cfg_reg_t;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef struct packed {
		logic h;
		logic first_row;
		logic emit;
		logic last;
	} job_flags_t;

endpackage

[sv/bsd_ifs.sv]
// valid/ready channel interfaces for pixels, results and configuration
`timescale 1ns / 1ps

interface bsd_pix_if;
	logic valid;
	logic ready;
	logic req_type;
	logic pixel;

	modport source (output valid, output req_type, output pixel, input ready);
	modport sink (input valid, input req_type, input pixel, output ready);
endinterface

interface bsd_res_if;
	logic valid;
	logic ready;
	logic dilated;
	logic frame_last;

	modport source (output valid, output dilated, output frame_last, input ready);
	modport sink (input valid, input dilated, input frame_last, output ready);
endinterface

interface bsd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bsd_pkg::CFG_IDX_W-1:0]  index;
	logic [bsd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/binary_square_dilation.sv]
// top level: configuration registers, front part, job queue and back part
// throughput: one item per cycle, stalled only by a full job queue of 4 entries
// path: an item's job goes through the job queue and the stage-1 registers into the output register
// a frame gives its last result on item grid_side*grid_side + radius*grid_side + radius
// reset: counters, queue and output clear, grid_side 1024 and radius 1 are restored
// column memory is not cleared, each column is written in the first row before its stored value is used
`timescale 1ns / 1ps

module binary_square_dilation #(
	parameter int MAX_SIDE   = 1024,
	parameter int MAX_RADIUS = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	bsd_pix_if.sink   pix,
	bsd_res_if.source res,
	bsd_cfg_if.sink   cfg
);
	import bsd_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int XW     = $clog2(MAX_SIDE);
	localparam int RW     = $clog2(MAX_RADIUS + 1);
	localparam int JOB_W  = XW + $bits(job_flags_t);
	localparam int NS_RST = (MAX_SIDE < 1024) ? MAX_SIDE : 1024;

	logic [SIDE_W-1:0] ns_q;
	logic [RW-1:0]     rad_q;
	logic              cfg_wr;

	logic          push;
	logic [XW-1:0] push_xc;
	job_flags_t    push_flags;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	logic [JOB_W-1:0] q_head;
	logic [XW-1:0] head_xc;
	job_flags_t    head_flags;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q  <= SIDE_W'(NS_RST);
			rad_q <= RW'(1);
		end else if (cfg_wr) begin
			if (cfg.index == REG_GRID_SIDE) begin
				if (cfg.data[GRID_W-1:0] == '0) begin
					ns_q <= SIDE_W'(1);
				end else if (32'(cfg.data[GRID_W-1:0]) > MAX_SIDE) begin
					ns_q <= SIDE_W'(MAX_SIDE);
				end else begin
					ns_q <= SIDE_W'(cfg.data[GRID_W-1:0]);
				end
			end else if (cfg.index == REG_RADIUS) begin
				if (32'(cfg.data[RAD_W-1:0]) > MAX_RADIUS) begin
					rad_q <= RW'(MAX_RADIUS);
				end else begin
					rad_q <= RW'(cfg.data[RAD_W-1:0]);
				end
			end
		end
	end

	bsd_front #(
		.MAX_SIDE   (MAX_SIDE),
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.ns         (ns_q),
		.rad        (rad_q),
		.pix        (pix),
		.q_full     (q_full),
		.push       (push),
		.push_xc    (push_xc),
		.push_flags (push_flags)
	);

	bsd_queue #(
		.DATA_W (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_xc, push_flags}),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	assign {head_xc, head_flags} = q_head;

	bsd_back #(
		.MAX_SIDE   (MAX_SIDE),
		.MAX_RADIUS (MAX_RADIUS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rad     (rad_q),
		.q_empty (q_empty),
		.q_xc    (head_xc),
		.q_flags (head_flags),
		.pop     (pop),
		.res     (res)
	);

endmodule

[sv/bsd_front.sv]
// front part: takes items, keeps the row window and counters, classifies column jobs
`timescale 1ns / 1ps

module bsd_front #(
	parameter int MAX_SIDE   = 1024,
	parameter int MAX_RADIUS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            restart,
	input  logic [$clog2(MAX_SIDE+1)-1:0]   ns,
	input  logic [$clog2(MAX_RADIUS+1)-1:0] rad,
	bsd_pix_if.sink                         pix,
	input  logic                            q_full,
	output logic                            push,
	output logic [$clog2(MAX_SIDE)-1:0]     push_xc,
	output bsd_pkg::job_flags_t             push_flags
);
	import bsd_pkg::*;

	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int XW       = $clog2(MAX_SIDE);
	localparam int RW       = $clog2(MAX_RADIUS + 1);
	localparam int LINE_LEN = 2 * MAX_RADIUS + 1;
	localparam int CYW      = $clog2(MAX_SIDE + MAX_RADIUS);
	localparam int MW       = ((XW > RW + 1) ? XW : RW + 1) + 2;

	logic [LINE_LEN-1:0] line_q;
	logic [LINE_LEN-1:0] line_n;
	logic [RW-1:0]       lead_q;
	logic [XW-1:0]       ix_q;
	logic [XW-1:0]       iy_q;
	logic                done_q;
	logic [XW-1:0]       cx_q;
	logic [CYW-1:0]      cy_q;

	logic [XW-1:0] ns_m1;
	logic          acc;
	logic          started;
	logic          pix_bit;
	logic          h;
	logic [MW-1:0] r_ext;
	logic [MW-1:0] r2;
	logic [MW-1:0] cx_ext;
	logic [MW-1:0] rem;
	logic          first_row;
	logic          emit;
	logic          last;
	logic          frame_end;

	assign pix.ready = !q_full;
	assign acc       = pix.valid && pix.ready;

	assign ns_m1   = XW'(ns - SIDE_W'(1));
	assign started = (lead_q == rad);
	assign pix_bit = (pix.req_type == REQ_PIXEL) && !done_q && pix.pixel;
	assign line_n  = {line_q[LINE_LEN-2:0], pix_bit};

	assign r_ext  = MW'(rad);
	assign r2     = r_ext << 1;
	assign cx_ext = MW'(cx_q);
	assign rem    = MW'(ns_m1) - MW'(cx_q);

	// horizontal or over the part of the window that stays in the row
	always_comb begin
		h = 1'b0;
		for (int k = 0; k < LINE_LEN; k++) begin
			if (line_n[k] && (MW'(k) <= r2) && (MW'(k) <= r_ext + cx_ext)
					&& (MW'(k) + rem >= r_ext)) begin
				h = 1'b1;
			end
		end
	end

	assign first_row = (cy_q == '0);
	assign emit      = (cy_q >= CYW'(rad));
	assign last      = (cy_q == CYW'(ns_m1) + CYW'(rad)) && (cx_q == ns_m1);
	assign frame_end = started && last;

	assign push       = acc && started;
	assign push_xc    = cx_q;
	assign push_flags = '{h: h, first_row: first_row, emit: emit, last: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			lead_q <= '0;
			ix_q   <= '0;
			iy_q   <= '0;
			done_q <= 1'b0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (restart) begin
			line_q <= '0;
			lead_q <= '0;
			ix_q   <= '0;
			iy_q   <= '0;
			done_q <= 1'b0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (acc) begin
			line_q <= line_n;
			if (frame_end) begin
				lead_q <= '0;
				ix_q   <= '0;
				iy_q   <= '0;
				done_q <= 1'b0;
				cx_q   <= '0;
				cy_q   <= '0;
			end else begin
				if (!started) begin
					lead_q <= RW'(lead_q + 1'b1);
				end else if (cx_q == ns_m1) begin
					cx_q <= '0;
					cy_q <= CYW'(cy_q + 1'b1);
				end else begin
					cx_q <= XW'(cx_q + 1'b1);
				end
				if (!done_q) begin
					if (ix_q == ns_m1) begin
						ix_q <= '0;
						if (iy_q == ns_m1) begin
							done_q <= 1'b1;
						end else begin
							iy_q <= XW'(iy_q + 1'b1);
						end
					end else begin
						ix_q <= XW'(ix_q + 1'b1);
					end
				end
			end
		end
	end

endmodule

[sv/bsd_queue.sv]
// short job queue between the front and back parts
`timescale 1ns / 1ps

module bsd_queue #(
	parameter int DATA_W = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] head,
	output logic              empty
);
	import bsd_pkg::*;

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= QCNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= QCNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

[sv/bsd_back.sv]
// back part: per-column distance memory, vertical or and the result register
`timescale 1ns / 1ps

module bsd_back #(
	parameter int MAX_SIDE   = 1024,
	parameter int MAX_RADIUS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(MAX_RADIUS+1)-1:0] rad,
	input  logic                            q_empty,
	input  logic [$clog2(MAX_SIDE)-1:0]     q_xc,
	input  bsd_pkg::job_flags_t             q_flags,
	output logic                            pop,
	bsd_res_if.source                       res
);
	import bsd_pkg::*;

	localparam int XW  = $clog2(MAX_SIDE);
	localparam int DW  = $clog2(2 * MAX_RADIUS + 2);
	localparam int SAT = 2 * MAX_RADIUS + 1;

	logic [DW-1:0] col_mem [MAX_SIDE];

	logic          vld_s1;
	logic [XW-1:0] xc_s1;
	job_flags_t    flg_s1;
	logic [DW-1:0] rd_s1;
	logic          byp_s1;
	logic [DW-1:0] bypd_s1;

	logic res_vld_q;
	logic dil_q;
	logic last_q;

	logic [DW-1:0] d_old;
	logic [DW-1:0] d_new;
	logic          adv;

	assign d_old = byp_s1 ? bypd_s1 : rd_s1;

	always_comb begin
		if (flg_s1.h) begin
			d_new = '0;
		end else if (flg_s1.first_row) begin
			d_new = DW'(SAT);
		end else if (d_old < DW'(SAT)) begin
			d_new = DW'(d_old + 1'b1);
		end else begin
			d_new = DW'(SAT);
		end
	end

	assign adv = vld_s1 && (!flg_s1.emit || !res_vld_q || res.ready);
	assign pop = !q_empty && (!vld_s1 || adv);

	assign res.valid      = res_vld_q;
	assign res.dilated    = dil_q;
	assign res.frame_last = last_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			col_mem[xc_s1] <= d_new;
		end
		if (pop) begin
			rd_s1 <= col_mem[q_xc];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			xc_s1   <= q_xc;
			flg_s1  <= q_flags;
			byp_s1  <= adv && (xc_s1 == q_xc);
			bypd_s1 <= d_new;
		end
		if (adv && flg_s1.emit) begin
			dil_q  <= (d_new <= (DW'(rad) << 1));
			last_q <= flg_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv && flg_s1.emit) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

endmodule

[sv/bsd_checker.sv]
// port checker for the binary square dilation block and its bind
`timescale 1ns / 1ps

module bsd_checker (
	input logic clk,
	input logic arst_n,
	input logic pix_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_dilated,
	input logic res_frame_last,
	input logic cfg_valid,
	input logic cfg_ready
);

	// a stalled result stays and holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_dilated)
			&& $stable(res_frame_last))
		else $error("stalled result changed or dropped");

	// no result is offered while in reset
	assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result offered during reset");

	// input backpressure only follows a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pix_ready) |-> $past(res_valid && !res_ready))
		else $error("input stalled without a stalled result");

	// configuration writes are never held off
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind binary_square_dilation bsd_checker u_bsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pix_ready      (pix.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_dilated    (res.dilated),
	.res_frame_last (res.frame_last),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready)
);

[sim/tb_top.sv]
// testbench for binary_square_dilation: frame streams checked against a dilation predictor
`timescale 1ns / 1ps

module tb_top;
	import bsd_pkg::*;

	localparam int SIDE_CAP    = 1024;
	localparam int RAD_CAP     = 15;
	localparam int LINE_BITS   = 2 * RAD_CAP + 1;
	localparam int COL_SAT     = LINE_BITS;
	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_FRAME  = 400;
	localparam int SETTLE      = 12;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic dilated;
		logic frame_last;
	} dil_result_t;

	class dilation_scoreboard;
		logic [GRID_W-1:0]    side_reg;
		logic [RAD_W-1:0]     rad_reg;
		logic [LINE_BITS-1:0] row_bits;
		int unsigned          col_age [SIDE_CAP];
		int unsigned          item_pos;
		dil_result_t          dilated_q[$];
		int                   mismatches;

		function new();
			side_reg = 11'd1024;
			rad_reg = 4'd1;
			foreach (col_age[k]) col_age[k] = COL_SAT;
			row_bits = '0;
			item_pos = 0;
			mismatches = 0;
		endfunction

		function int unsigned side_eff();
			if (side_reg == 0) return 1;
			if (side_reg > SIDE_CAP) return SIDE_CAP;
			return side_reg;
		endfunction

		function int unsigned rad_eff();
			return (rad_reg > RAD_CAP) ? RAD_CAP : rad_reg;
		endfunction

		function int pending();
			return dilated_q.size();
		endfunction

		// any write restarts the frame
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_GRID_SIDE) side_reg = data[GRID_W-1:0];
			else if (idx == REG_RADIUS) rad_reg = data[RAD_W-1:0];
			row_bits = '0;
			item_pos = 0;
		endfunction

		function void note_item(logic req, logic pix);
			int unsigned ns, r, npix, c, yc, xc, row0, lo, hi, d;
			logic bit_in, h;
			dil_result_t res_item;
			ns = side_eff();
			r = rad_eff();
			npix = ns * ns;
			bit_in = (req == REQ_PIXEL && item_pos < npix) ? pix : 1'b0;
			row_bits = {row_bits[LINE_BITS-2:0], bit_in};
			if (item_pos >= r) begin
				c = item_pos - r;
				yc = c / ns;
				xc = c % ns;
				row0 = yc * ns;
				lo = (c >= row0 + r) ? c - r : row0;
				hi = (c + r <= row0 + ns - 1) ? c + r : row0 + ns - 1;
				h = 1'b0;
				for (int unsigned p = lo; p <= hi; p++) begin
					if (item_pos - p < LINE_BITS && row_bits[item_pos - p]) h = 1'b1;
				end
				d = col_age[xc];
				if (h) d = 0;
				else if (yc == 0) d = COL_SAT;
				else if (d < COL_SAT) d = d + 1;
				col_age[xc] = d;
				if (c >= r * ns) begin
					res_item.dilated = (d <= 2 * r);
					res_item.frame_last = ((c - r * ns) == npix - 1);
					dilated_q = {dilated_q, res_item};
				end
			end
			if (item_pos >= npix - 1 + r * ns + r) item_pos = 0;
			else item_pos = item_pos + 1;
		endfunction

		function void check_result(logic dil, logic last);
			dil_result_t want;
			if (dilated_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: dilated %0b frame_last %0b", dil, last);
			end else begin
				want = dilated_q.pop_front();
				if (want.dilated !== dil || want.frame_last !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected dilated %0b frame_last %0b, got %0b %0b",
							want.dilated, want.frame_last, dil, last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bsd_pix_if pix_ch();
	bsd_res_if res_ch();
	bsd_cfg_if cfg_ch();

	binary_square_dilation u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	dilation_scoreboard board = new();
	bit quiet_tx;
	bit quiet_rx;
	bit hold_next;
	int random_sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int draw_wait(bit quiet);
		if (quiet) return 0;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 18);
			1: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	function automatic logic draw_pixel(int dens);
		return ($urandom_range(0, 7) < dens);
	endfunction

	task automatic send_item(logic req, logic pix);
		int gap;
		gap = draw_wait(quiet_tx);
		if (hold_next) begin
			hold_next = 1'b0;
			pix_ch.valid <= 1'b0;
			@(posedge clk);
			while (board.pending() != 0) @(posedge clk);
		end else if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.req_type <= req;
		pix_ch.pixel <= pix;
		do @(posedge clk); while (!pix_ch.ready);
		board.note_item(req, pix);
		if ($urandom_range(0, 99) == 0) hold_next = 1'b1;
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		board.write_reg(idx, data);
	endtask

	// mode 0 well formed, 1 noise, 2 cut short; any frame over LONG_FRAME items is cut to 20 to 60
	task automatic send_frame(int mode);
		int unsigned npix, len;
		int dens;
		logic req;
		npix = board.side_eff() * board.side_eff();
		len = npix + board.rad_eff() * board.side_eff() + board.rad_eff();
		dens = $urandom_range(1, 7);
		if (mode == 2 && len > 1) len = $urandom_range(1, len - 1);
		if (len > LONG_FRAME) len = $urandom_range(20, 60);
		for (int unsigned k = 0; k < len; k++) begin
			if (mode == 1) req = ($urandom_range(0, 3) == 0) ? (k < npix ? REQ_FLUSH : REQ_PIXEL)
				: (k < npix ? REQ_PIXEL : REQ_FLUSH);
			else req = (k < npix) ? REQ_PIXEL : REQ_FLUSH;
			send_item(req, draw_pixel(dens));
		end
		random_sent += len;
	endtask

	initial begin : result_sink
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait(quiet_rx);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			board.check_result(res_ch.dilated, res_ch.frame_last);
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int unsigned side_v, rad_v, frames;
		arst_n <= 1'b0;
		pix_ch.valid <= 1'b0;
		pix_ch.req_type <= REQ_PIXEL;
		pix_ch.pixel <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_GRID_SIDE;
		cfg_ch.data <= '0;
		quiet_tx = 1'b1;
		quiet_rx = 1'b1;
		hold_next = 1'b0;
		random_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full side, radius 1, start of the first row of outputs
		for (int k = 0; k < 1046; k++) send_item(REQ_PIXEL, $urandom_range(0, 15) == 0);

		// small frame with a flush inside and a pixel after the pixels
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		write_cfg(REG_GRID_SIDE, 11'd3);
		write_cfg(REG_RADIUS, 11'd1);
		send_item(REQ_PIXEL, 1'b1);
		send_item(REQ_PIXEL, 1'b0);
		send_item(REQ_FLUSH, 1'b1);
		send_item(REQ_PIXEL, 1'b0);
		hold_next = 1'b1;
		send_item(REQ_PIXEL, 1'b1);
		send_item(REQ_PIXEL, 1'b0);
		send_item(REQ_PIXEL, 1'b0);
		send_item(REQ_PIXEL, 1'b0);
		send_item(REQ_PIXEL, 1'b1);
		send_item(REQ_FLUSH, 1'b0);
		send_item(REQ_PIXEL, 1'b1);
		send_item(REQ_FLUSH, 1'b1);
		send_item(REQ_FLUSH, 1'b0);

		// side zero acts as one, radius zero passes through
		write_cfg(REG_GRID_SIDE, 11'd0);
		write_cfg(REG_RADIUS, 11'd0);
		send_item(REQ_PIXEL, 1'b1);
		send_item(REQ_PIXEL, 1'b0);
		send_item(REQ_FLUSH, 1'b1);

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			quiet_tx = ($urandom_range(0, 3) == 0);
			quiet_rx = ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				write_cfg(REG_GRID_SIDE, 11'h7FF);
				write_cfg(REG_SPARE_2, CFG_DATA_W'($urandom));
			end else if (phase == 1) begin
				write_cfg(REG_GRID_SIDE, 11'd2);
				write_cfg(REG_RADIUS, 11'h7FF);
				write_cfg(REG_SPARE_3, CFG_DATA_W'($urandom));
				write_cfg(REG_GRID_SIDE, 11'd2);
			end else begin
				case ($urandom_range(0, 9))
					0: side_v = 0;
					1: side_v = $urandom_range(9, 14);
					default: side_v = $urandom_range(1, 8);
				endcase
				rad_v = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
				if (rad_v > 6 && side_v > 4) side_v = $urandom_range(1, 4);
				case ($urandom_range(0, 3))
					0: write_cfg(REG_GRID_SIDE, CFG_DATA_W'(side_v));
					1: write_cfg(REG_RADIUS, {7'($urandom), 4'(rad_v)});
					default: begin
						write_cfg(REG_RADIUS, {7'($urandom), 4'(rad_v)});
						write_cfg(REG_GRID_SIDE, CFG_DATA_W'(side_v));
					end
				endcase
				if ($urandom_range(0, 5) == 0)
					write_cfg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
						CFG_DATA_W'($urandom));
			end
			frames = $urandom_range(1, 3);
			for (int unsigned f = 0; f < frames; f++) begin
				case ($urandom_range(0, 7))
					0: send_frame(1);
					1: send_frame(2);
					default: send_frame(0);
				endcase
			end
			phase++;
		end

		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[binary_square_dilation.f]
sv/bsd_pkg.sv
sv/bsd_ifs.sv
sv/bsd_front.sv
sv/bsd_queue.sv
sv/bsd_back.sv
sv/binary_square_dilation.sv
sv/bsd_checker.sv
sim/tb_top.sv
